// File: design/lwpm_pkg.sv
// shared types, constants and helpers of the last wildcard pattern match block
`timescale 1ns / 1ps
`default_nettype none

package lwpm_pkg;

    localparam int BYTE_W          = 8;
    localparam int PATTERN_BYTES   = 32;
    localparam int PAT_IDX_W       = 5;
    localparam int CFG_W           = 64;
    localparam int CFG_WORDS       = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int LEN_W           = 6;
    localparam int OFFSET_W        = 16;
    localparam int COUNT_W         = 17;
    localparam int MAX_PATTERN_DEF = 32;

    localparam logic [BYTE_W-1:0]   ANY_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0]   ANY_DIGIT  = 8'hFE;
    localparam logic [BYTE_W-1:0]   CHAR_0     = 8'h30;
    localparam logic [BYTE_W-1:0]   CHAR_9     = 8'h39;
    localparam logic [OFFSET_W-1:0] OFFSET_CAP = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_0_7   = 3'd0,
        CFG_PAT_8_15  = 3'd1,
        CFG_PAT_16_23 = 3'd2,
        CFG_PAT_24_31 = 3'd3,
        CFG_LEN       = 3'd4
    } t_cfg_idx;

    typedef logic [CFG_WORDS-1:0][CFG_W-1:0] t_pattern;

    typedef struct packed {
        t_pattern         pattern;
        logic [LEN_W-1:0] len;
    } t_cfg;

    // one pattern byte against one text byte, with the two wildcard codes
    function automatic logic byte_ok(input logic [BYTE_W-1:0] p, input logic [BYTE_W-1:0] t);
        logic ok;
        if (p == ANY_BYTE) begin
            ok = 1'b1;
        end else if (p == ANY_DIGIT) begin
            ok = t inside {[CHAR_0:CHAR_9]};
        end else begin
            ok = (p == t);
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// File: design/lwpm_in_if.sv
// input channel: one text byte and its last-byte mark per word
`timescale 1ns / 1ps
`default_nettype none

interface lwpm_in_if;
    logic                      valid;
    logic                      ready;
    logic [lwpm_pkg::BYTE_W-1:0] text_byte;
    logic                      final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// File: design/lwpm_out_if.sv
// output channel: one search result per word
`timescale 1ns / 1ps
`default_nettype none

interface lwpm_out_if;
    logic                          valid;
    logic                          ready;
    logic                          match_found;
    logic [lwpm_pkg::OFFSET_W-1:0] match_offset;

    modport source (output valid, output match_found, output match_offset, input ready);
    modport sink   (input valid, input match_found, input match_offset, output ready);
endinterface

`default_nettype wire

// File: design/lwpm_cfg.sv
// configuration register file: pattern words and pattern length
`timescale 1ns / 1ps
`default_nettype none

module lwpm_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lwpm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lwpm_pkg::CFG_W-1:0]     i_cfg_data,
    output lwpm_pkg::t_cfg                      o_cfg
);
    import lwpm_pkg::*;

    t_pattern         r_pattern;
    logic [LEN_W-1:0] r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_len     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAT_0_7:   r_pattern[0] <= i_cfg_data;
                CFG_PAT_8_15:  r_pattern[1] <= i_cfg_data;
                CFG_PAT_16_23: r_pattern[2] <= i_cfg_data;
                CFG_PAT_24_31: r_pattern[3] <= i_cfg_data;
                CFG_LEN:       r_len        <= i_cfg_data[LEN_W-1:0];
                default: begin
                    // unknown index, ignored
                end
            endcase
        end
    end

    assign o_cfg.pattern = r_pattern;
    assign o_cfg.len     = r_len;

endmodule

`default_nettype wire

// File: design/lwpm_match.sv
// window compare: each live pattern byte against the text byte at its age
`timescale 1ns / 1ps
`default_nettype none

module lwpm_match #(
    parameter int MAX_PATTERN = lwpm_pkg::MAX_PATTERN_DEF
) (
    input  lwpm_pkg::t_pattern                                 i_pattern,
    input  wire logic [lwpm_pkg::LEN_W-1:0]                    i_len,
    input  wire logic [MAX_PATTERN-1:0][lwpm_pkg::BYTE_W-1:0]  i_window,
    output logic                                               o_all_ok
);
    import lwpm_pkg::*;

    logic [PATTERN_BYTES-1:0][BYTE_W-1:0] w_bytes;
    logic [MAX_PATTERN-1:0][PAT_IDX_W-1:0] w_idx;
    logic [MAX_PATTERN-1:0]                w_ok;

    assign w_bytes = i_pattern;

    // window age a lines up with pattern byte len-1-a; ages at or past len are free
    always_comb begin
        for (int a = 0; a < MAX_PATTERN; a++) begin
            w_idx[a] = PAT_IDX_W'(i_len - LEN_W'(a + 1));
            w_ok[a]  = (LEN_W'(a) >= i_len) || byte_ok(w_bytes[w_idx[a]], i_window[a]);
        end
    end

    assign o_all_ok = &w_ok;

endmodule

`default_nettype wire

// File: design/last_wildcard_pattern_match.sv
// top level of the last wildcard pattern match block
// Searches a byte string, one byte per input word, for the last occurrence of a
// configured pattern of up to MAX_PATTERN bytes, where pattern byte 0xFF matches
// any byte and 0xFE any ASCII digit. On the word carrying the last-byte mark one
// result word is produced: match_found and the start offset of the latest match
// (saturated at 65535), or 0/0 when there is none; an empty pattern matches at
// the string length. The block takes one byte per cycle, sustained while no last
// byte waits; a result word passes from the window register, which doubles as the
// input register, to the result register, with a single pass of parallel byte
// compares between them. A last byte waits in the window register while an
// earlier result word is not taken. Configuration is to be written by the user
// only while no word is inside the block, which the block does not enforce; a
// write between the bytes of a string takes effect from the next byte.
`timescale 1ns / 1ps
`default_nettype none

module last_wildcard_pattern_match #(
    parameter int MAX_PATTERN = lwpm_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    lwpm_in_if.sink                             i_in,
    lwpm_out_if.source                          o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [lwpm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lwpm_pkg::CFG_W-1:0]     i_cfg_data
);
    import lwpm_pkg::*;

    // clamp a wide count to the reported offset range
    function automatic logic [OFFSET_W-1:0] sat_offset(input logic [COUNT_W-1:0] v);
        logic [OFFSET_W-1:0] s;
        if (v > COUNT_W'(OFFSET_CAP)) begin
            s = OFFSET_CAP;
        end else begin
            s = v[OFFSET_W-1:0];
        end
        return s;
    endfunction

    // configuration
    t_cfg             w_cfg;
    logic [LEN_W-1:0] w_len;

    lwpm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // lengths above the window depth use the whole window
    assign w_len = (w_cfg.len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : w_cfg.len;

    // input register: window of the newest bytes, newest at entry 0
    logic                               r_s1_valid;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] r_window;
    logic                               r_s1_last;

    // per-string state
    logic [COUNT_W-1:0]     r_count;
    logic [OFFSET_W-1:0]    r_latest;
    logic                   r_seen;

    // result register
    logic                r_out_valid;
    logic                r_found;
    logic [OFFSET_W-1:0] r_offset;

    logic w_out_free;
    logic w_s1_go;
    logic w_in_take;

    // a plain byte always moves on; a last byte waits for room in the result register
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s1_go    = r_s1_valid && (!r_s1_last || w_out_free);
    assign i_in.ready = !r_s1_valid || w_s1_go;
    assign w_in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // the window shifts by one byte per accepted word; bytes of an earlier string
    // are never compared since a hit needs at least pattern length bytes seen
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (w_in_take) begin
            r_window[0] <= i_in.text_byte;
            for (int a = 1; a < MAX_PATTERN; a++) begin
                r_window[a] <= r_window[a-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_last <= i_in.final_byte;
        end
    end

    // full window compare against the current pattern
    logic w_all_ok;
    logic w_hit;

    lwpm_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .i_pattern (w_cfg.pattern),
        .i_len     (w_len),
        .i_window  (r_window),
        .o_all_ok  (w_all_ok)
    );

    // byte count, saturating, and start of a match ending here
    logic [COUNT_W-1:0]  n_count;
    logic [COUNT_W-1:0]  w_start;
    logic [OFFSET_W-1:0] n_latest;
    logic                n_found;
    logic [OFFSET_W-1:0] n_offset;

    assign n_count  = (&r_count) ? r_count : r_count + COUNT_W'(1);
    assign w_hit    = (w_len != '0) && (n_count >= COUNT_W'(w_len)) && w_all_ok;
    assign w_start  = n_count - COUNT_W'(w_len);
    assign n_latest = w_hit ? sat_offset(w_start) : r_latest;

    always_comb begin
        if (w_len == '0) begin
            // empty pattern: match at the string length
            n_found  = 1'b1;
            n_offset = sat_offset(n_count);
        end else if (w_hit || r_seen) begin
            n_found  = 1'b1;
            n_offset = n_latest;
        end else begin
            n_found  = 1'b0;
            n_offset = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_latest <= '0;
            r_seen   <= 1'b0;
        end else if (w_s1_go) begin
            if (r_s1_last) begin
                // string closed, back to a clean start
                r_count  <= '0;
                r_latest <= '0;
                r_seen   <= 1'b0;
            end else begin
                r_count  <= n_count;
                r_latest <= n_latest;
                r_seen   <= r_seen | w_hit;
            end
        end
    end

    // result register, refilled in the cycle it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go && r_s1_last) begin
            r_found  <= n_found;
            r_offset <= n_offset;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.match_found  = r_found;
    assign o_out.match_offset = r_offset;

endmodule

`default_nettype wire

// File: design/lwpm_checker.sv
// port-level checks of the last wildcard pattern match block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module lwpm_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          i_out_found,
    input wire logic [lwpm_pkg::OFFSET_W-1:0] i_out_offset
);
    import lwpm_pkg::*;

    // a word left waiting holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_found)
            && $stable(i_out_offset))
        else $error("result word changed while stalled");

    // no result word straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word after reset");

    // a miss always reports offset zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> i_out_offset == '0)
        else $error("miss with non-zero offset");

    // with the result register empty the input side never stalls
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind last_wildcard_pattern_match lwpm_checker u_lwpm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_found  (o_out.match_found),
    .i_out_offset (o_out.match_offset)
);

`default_nettype wire

// File: test/match_check_pkg.sv
// result type and last-match tracker used to check the pattern search block
`timescale 1ns / 1ps

package match_check_pkg;
    import lwpm_pkg::*;

    localparam int COUNT_CAP = 131071;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } t_search_result;

    class match_tracker;
        logic [CFG_W-1:0]   pat_word [CFG_WORDS];
        logic [LEN_W-1:0]   pat_len;
        logic [BYTE_W-1:0]  window [PATTERN_BYTES];
        logic [COUNT_W-1:0] seen_count;
        logic [COUNT_W-1:0] latest_start;
        logic               seen_match;
        t_search_result     pending_results [$];
        int                 errors;

        function new();
            foreach (pat_word[w]) pat_word[w] = '0;
            pat_len = '0;
            errors  = 0;
            clear_string();
        endfunction

        function void clear_string();
            foreach (window[k]) window[k] = '0;
            seen_count   = '0;
            latest_start = '0;
            seen_match   = 1'b0;
        endfunction

        // unknown indexes fall through and change nothing
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_PAT_0_7:   pat_word[0] = val;
                CFG_PAT_8_15:  pat_word[1] = val;
                CFG_PAT_16_23: pat_word[2] = val;
                CFG_PAT_24_31: pat_word[3] = val;
                CFG_LEN:       pat_len = val[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b, logic last);
            int                  used;
            int                  k;
            logic                hit;
            logic [BYTE_W-1:0]   p;
            logic [BYTE_W-1:0]   t;
            logic [COUNT_W-1:0]  at;
            t_search_result      res;
            for (k = PATTERN_BYTES - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = b;
            if (seen_count != COUNT_W'(COUNT_CAP)) seen_count = seen_count + 1'b1;
            used = (pat_len > PATTERN_BYTES) ? PATTERN_BYTES : int'(pat_len);
            if (used > 0 && int'(seen_count) >= used) begin
                hit = 1'b1;
                for (k = 0; k < used; k++) begin
                    p = pat_word[k / 8][(k % 8) * BYTE_W +: BYTE_W];
                    t = window[used - 1 - k];
                    if (p == ANY_DIGIT) begin
                        if (t < CHAR_0 || t > CHAR_9) hit = 1'b0;
                    end else if (p != ANY_BYTE && p != t) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    latest_start = COUNT_W'(int'(seen_count) - used);
                    seen_match   = 1'b1;
                end
            end
            if (last) begin
                if (used == 0) begin
                    at        = seen_count;
                    res.found = 1'b1;
                end else begin
                    at        = seen_match ? latest_start : '0;
                    res.found = seen_match;
                end
                res.offset = (at > OFFSET_CAP) ? OFFSET_CAP : at[OFFSET_W-1:0];
                pending_results.push_back(res);
                clear_string();
            end
        endfunction

        function void check_result(logic found, logic [OFFSET_W-1:0] offset);
            t_search_result want;
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: match_found %0d, match_offset %0d",
                       found, offset);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (found !== want.found) begin
                $error("match_found: expected %0d, got %0d", want.found, found);
                errors++;
            end
            if (offset !== want.offset) begin
                $error("match_offset: expected %0d, got %0d", want.offset, offset);
                errors++;
            end
        endfunction
    endclass

endpackage

// File: test/tb_top.sv
// top of the testbench for the last wildcard pattern match block
`timescale 1ns / 1ps

module tb_top;
    import lwpm_pkg::*;
    import match_check_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 4;
    localparam int STALL_LIMIT    = 2000;  // cycles with no handshake and no register write
    localparam int RX_HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS    = 120;
    localparam int PHASE_COUNT    = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    lwpm_in_if  in_ch ();
    lwpm_out_if out_ch ();

    last_wildcard_pattern_match u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    match_tracker tracker = new();

    // pattern as the stimulus side sees it, kept to plant occurrences in the text
    logic [BYTE_W-1:0] pat_tb [PATTERN_BYTES];
    int                pat_used    = 0;
    logic [BYTE_W-1:0] text_q [$];
    bit                calm        = 1'b0; // no gaps on either side
    bit                wide        = 1'b0; // full byte range instead of a small alphabet
    bit                rx_hold_req = 1'b0;
    int                str_max     = 12;
    int                bytes_sent  = 0;
    int                idle_cycles = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    // ---------------------------------------------------------------- random picks

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_run();
        if (calm) return 200;
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(20, 80);
    endfunction

    // small alphabet keeps matches frequent; includes the wildcard codes as text
    function automatic logic [BYTE_W-1:0] pick_text_byte();
        if (wide) return BYTE_W'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0:       return 8'h61;
            1:       return 8'h00;
            2:       return ANY_DIGIT;
            3:       return ANY_BYTE;
            default: return BYTE_W'(CHAR_0 + $urandom_range(0, 2));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_pattern_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return ANY_BYTE;
        if (r < 4) return ANY_DIGIT;
        return pick_text_byte();
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, str_max);
        return $urandom_range(1, 70);
    endfunction

    function automatic logic [CFG_W-1:0] pat_word(input int w);
        logic [CFG_W-1:0] word;
        int               b;
        for (b = 0; b < CFG_W / BYTE_W; b++)
            word[b*BYTE_W +: BYTE_W] = pat_tb[w*(CFG_W/BYTE_W) + b];
        return word;
    endfunction

    // ---------------------------------------------------------------- drivers

    // valid is only lowered when a gap follows, so back-to-back words keep it high
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.text_byte  <= b;
        in_ch.final_byte <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_text();
        int j;
        for (j = 0; j < text_q.size(); j++) send_byte(text_q[j], j == text_q.size() - 1);
    endtask

    // random string, often with one occurrence of the pattern dropped in
    task automatic send_string(input int n);
        int pos;
        int j;
        text_q.delete();
        for (j = 0; j < n; j++) text_q.push_back(pick_text_byte());
        if (pat_used > 0 && pat_used <= n && $urandom_range(0, 9) < 6) begin
            pos = $urandom_range(0, n - pat_used);
            for (j = 0; j < pat_used; j++) begin
                if (pat_tb[j] == ANY_BYTE)
                    text_q[pos+j] = BYTE_W'($urandom_range(0, 255));
                else if (pat_tb[j] == ANY_DIGIT)
                    text_q[pos+j] = BYTE_W'(CHAR_0 + $urandom_range(0, 9));
                else
                    text_q[pos+j] = pat_tb[j];
            end
        end
        send_text();
    endtask

    // write enable stays high across a burst of writes; the caller lowers it
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // waits for every pending result and a short settle, then writes all registers
    task automatic load_pattern(input logic [LEN_W-1:0] len, input bit spare);
        int i;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        put_reg(CFG_PAT_0_7,   pat_word(0));
        put_reg(CFG_PAT_8_15,  pat_word(1));
        put_reg(CFG_PAT_16_23, pat_word(2));
        put_reg(CFG_PAT_24_31, pat_word(3));
        put_reg(CFG_LEN,       CFG_W'(len));
        if (spare) begin
            for (i = CFG_IDX_SPARE_LO; i <= CFG_IDX_SPARE_HI; i++)
                put_reg(i[CFG_IDX_W-1:0], {$urandom, $urandom});
        end
        i_cfg_we <= 1'b0;
        pat_used = (len > PATTERN_BYTES) ? PATTERN_BYTES : int'(len);
    endtask

    // ---------------------------------------------------------------- result side

    // ready toggles in runs; one long hold-off on request to back the block up
    initial begin
        int on_len;
        int off_len;
        out_ch.ready <= 1'b1;
        forever begin
            on_len = pick_run();
            repeat (on_len) @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                off_len     = RX_HOLD_CYCLES;
            end else begin
                off_len = pick_gap();
            end
            if (off_len > 0) begin
                out_ch.ready <= 1'b0;
                repeat (off_len) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    // samples pre-edge values: register writes, accepted bytes, accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) tracker.set_reg(i_cfg_idx, i_cfg_data);
            if (in_ch.valid && in_ch.ready)
                tracker.take_byte(in_ch.text_byte, in_ch.final_byte);
            if (out_ch.valid && out_ch.ready)
                tracker.check_result(out_ch.match_found, out_ch.match_offset);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        int               ph;
        int               target;
        logic [LEN_W-1:0] len;
        bit               spare;
        in_ch.valid      <= 1'b0;
        in_ch.text_byte  <= '0;
        in_ch.final_byte <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_PAT_0_7;
        i_cfg_data       <= '0;
        i_rst_n          <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pattern out of reset: match at the string length, zero bytes ordinary
        text_q = '{8'h00};
        send_text();
        text_q = '{8'hFF, 8'h00, 8'h7F};
        send_text();

        // "1", any digit, any byte, zero byte
        foreach (pat_tb[k]) pat_tb[k] = '0;
        pat_tb[0] = 8'h31;
        pat_tb[1] = ANY_DIGIT;
        pat_tb[2] = ANY_BYTE;
        pat_tb[3] = 8'h00;
        load_pattern(4, 1'b0);
        text_q = '{8'h31, 8'h35, 8'h5A, 8'h00};          // match at the start
        send_text();
        text_q = '{8'h31, ANY_DIGIT, 8'h5A, 8'h00};       // 0xfe in the text is no digit
        send_text();
        text_q = '{8'h31, 8'h37};                         // pattern longer than string
        send_text();
        text_q = '{8'h31, 8'h37, 8'h80, 8'h00,
                   8'h31, 8'h39, 8'hFF, 8'h00};           // two hits, the later one counts
        send_text();

        // random phases, each with its own pattern setting
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            wide    = (ph == 4 || ph == 5);
            calm    = (ph == 5);
            spare   = (ph == 1);
            str_max = 12;
            foreach (pat_tb[k]) pat_tb[k] = pick_pattern_byte();
            case (ph)
                0: len = 1;
                1: len = LEN_W'($urandom_range(2, 6));
                2: begin
                    len     = PATTERN_BYTES;
                    str_max = 48;
                end
                3: begin                                  // length above the maximum
                    len     = '1;
                    str_max = 48;
                end
                4: len = '0;
                5: len = LEN_W'($urandom_range(3, 8));
                6: begin                                  // short strings to pile results up
                    len     = 2;
                    str_max = 3;
                end
                7: begin                                  // all wildcards, all-ones words
                    foreach (pat_tb[k]) pat_tb[k] = ANY_BYTE;
                    len     = PATTERN_BYTES + 1;
                    str_max = 48;
                end
                default: begin                            // all-zero words
                    foreach (pat_tb[k]) pat_tb[k] = '0;
                    len = LEN_W'($urandom_range(1, 12));
                end
            endcase
            load_pattern(len, spare);
            if (ph == 6) rx_hold_req = 1'b1;
            target = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < target) send_string(pick_len());
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
